// File: hw/rtl/esl_pkg.sv
// ----------------------------------------------------------------------------
// esl_pkg
// Shared types, codes and constants of the event sequence load checker,
// including the CRC-32 update matrix that is built at elaboration.
// ----------------------------------------------------------------------------
package esl_pkg;

    localparam int MAX_EVENTS = 4096;
    localparam int MIN_EVENTS = 1;
    // Wide enough to hold MAX_EVENTS itself.
    localparam int CNT_W      = $clog2(MAX_EVENTS + 1);
    localparam int SLOT_W     = 12;
    localparam int CRC_DATA_W = 128;
    localparam int CRC_COLS   = 32 + CRC_DATA_W;

    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [31:0] MASK_RST = 32'h0000_00FF;

    typedef enum logic [1:0] {
        CMD_BEGIN  = 2'd0,
        CMD_EVENT  = 2'd1,
        CMD_COMMIT = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        STAT_OK           = 3'd0,
        STAT_BAD_STATE    = 3'd1,
        STAT_BAD_SEQUENCE = 3'd2,
        STAT_BAD_INDEX    = 3'd3,
        STAT_CRC_MISMATCH = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        FLT_NONE        = 3'd0,
        FLT_COUNT       = 3'd1,
        FLT_RESERVED    = 3'd2,
        FLT_FLAGS       = 3'd3,
        FLT_NO_CHANGE   = 3'd4,
        FLT_TIME_ORDER  = 3'd5,
        FLT_UNSAFE_LAST = 3'd6
    } t_fault;

    typedef struct packed {
        t_cmd        cmd;
        logic [31:0] evt_total;
        logic [31:0] expected_crc;
        logic [31:0] evt_pos;
        logic [63:0] timestamp;
        logic [31:0] out_pattern;
        logic [31:0] event_flags;
        logic        sequencer_idle;
    } t_item;

    typedef struct packed {
        t_status           status;
        t_fault            fault;
        logic [31:0]       report_a;
        logic [31:0]       report_b;
        logic              load_active;
        logic              load_committed;
        logic              store_event;
        logic [SLOT_W-1:0] store_index;
    } t_result;

    typedef logic [CRC_COLS-1:0][31:0] t_crc_mat;

    // Bit-serial reflected CRC over 128 data bits, bit 0 first.
    function automatic logic [31:0] crc_serial(logic [31:0] crc,
                                               logic [CRC_DATA_W-1:0] data);
        logic [31:0] c;
        c = crc;
        for (int b = 0; b < CRC_DATA_W; b++) begin
            if (c[0] ^ data[b]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    // The update is linear: column i is the response to a single set bit,
    // first the 32 CRC bits, then the 128 data bits.
    function automatic t_crc_mat build_crc_mat();
        t_crc_mat m;
        for (int i = 0; i < CRC_COLS; i++) begin
            if (i < 32) begin
                m[i] = crc_serial(32'd1 << i, '0);
            end else begin
                m[i] = crc_serial('0, {{(CRC_DATA_W-1){1'b0}}, 1'b1} << (i - 32));
            end
        end
        return m;
    endfunction

    localparam t_crc_mat CRC_MAT = build_crc_mat();

endpackage

// File: hw/rtl/event_sequence_load_checker.sv
// ----------------------------------------------------------------------------
// event_sequence_load_checker
// Checks a timed output-event sequence while it is loaded and strobes each
// accepted event out for storage.
// ----------------------------------------------------------------------------
// A user of this block sends one command beat at a time (begin, event,
// commit or clear) and gets exactly one result beat back for each. The
// block takes one beat per clock cycle when the result side keeps up: each
// beat is captured in an input register, checked against the load state by
// a single level of logic (the compares and a one-step 128-bit CRC-32 fold
// built as a fixed XOR matrix), and the result is registered as the beat
// moves on, so a result beat becomes valid once its command beat has passed
// through the input register and then the result register. The
// load state is updated on the same edge that registers the result, so the
// next beat, already waiting in the input register, sees it without a
// bubble. When the result side stalls, the input side keeps taking a beat
// as long as the input register is free or moves on in that cycle. The output
// mask register, written through i_cfg_we and i_cfg_wdata, resets to the low
// eight output bits; the user writes it only while no beat is in flight (the block does not enforce this).
// ----------------------------------------------------------------------------
module event_sequence_load_checker
    import esl_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,

    // Configuration: output mask.
    input  logic              i_cfg_we,
    input  logic [31:0]       i_cfg_wdata,

    // Command channel.
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [1:0]        i_cmd,
    input  logic [31:0]       i_evt_total,
    input  logic [31:0]       i_expected_crc,
    input  logic [31:0]       i_evt_pos,
    input  logic [63:0]       i_timestamp,
    input  logic [31:0]       i_out_pattern,
    input  logic [31:0]       i_event_flags,
    input  logic              i_sequencer_idle,

    // Result channel.
    output logic              o_valid,
    input  logic              i_ready,
    output logic [2:0]        o_status,
    output logic [2:0]        o_fault,
    output logic [31:0]       o_report_a,
    output logic [31:0]       o_report_b,
    output logic              o_load_active,
    output logic              o_load_committed,
    output logic              o_store_event,
    output logic [SLOT_W-1:0] o_store_index
);

    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;
    t_result result;
    logic    step;

    // The buffered beat is processed whenever the result register is empty
    // or is being emptied in this cycle.
    assign step    = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in.cmd            <= t_cmd'(i_cmd);
            r_in.evt_total      <= i_evt_total;
            r_in.expected_crc   <= i_expected_crc;
            r_in.evt_pos        <= i_evt_pos;
            r_in.timestamp      <= i_timestamp;
            r_in.out_pattern    <= i_out_pattern;
            r_in.event_flags    <= i_event_flags;
            r_in.sequencer_idle <= i_sequencer_idle;
        end
    end

    esl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_item      (r_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_result    (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= result;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_status         = r_out.status;
    assign o_fault          = r_out.fault;
    assign o_report_a       = r_out.report_a;
    assign o_report_b       = r_out.report_b;
    assign o_load_active    = r_out.load_active;
    assign o_load_committed = r_out.load_committed;
    assign o_store_event    = r_out.store_event;
    assign o_store_index    = r_out.store_index;

endmodule

// File: hw/rtl/esl_crc.sv
// ----------------------------------------------------------------------------
// esl_crc
// Folds one 128-bit event record into a reflected CRC-32 in a single step,
// using the precomputed XOR matrix.
// ----------------------------------------------------------------------------
module esl_crc
    import esl_pkg::*;
(
    input  logic [31:0]           i_crc,
    input  logic [CRC_DATA_W-1:0] i_data,
    output logic [31:0]           o_crc
);

    always_comb begin
        logic [31:0] acc;
        acc = '0;
        for (int i = 0; i < 32; i++) begin
            if (i_crc[i]) begin
                acc = acc ^ CRC_MAT[i];
            end
        end
        for (int j = 0; j < CRC_DATA_W; j++) begin
            if (i_data[j]) begin
                acc = acc ^ CRC_MAT[32 + j];
            end
        end
        o_crc = acc;
    end

endmodule

// File: hw/rtl/esl_ctrl.sv
// ----------------------------------------------------------------------------
// esl_ctrl
// Load state, output mask register and the per-beat decision logic. The
// state advances on i_step, the same edge at which the result is registered.
// ----------------------------------------------------------------------------
module esl_ctrl
    import esl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  t_item       i_item,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    output t_result     o_result
);

    logic             r_active,    n_active;
    logic             r_committed, n_committed;
    logic [CNT_W-1:0] r_announced, n_announced;
    logic [CNT_W-1:0] r_next,      n_next;
    logic [31:0]      r_target,    n_target;
    logic [31:0]      r_crc,       n_crc;
    logic [63:0]      r_last_time, n_last_time;
    logic [31:0]      r_last_st,   n_last_st;
    logic [31:0]      r_mask;

    logic [31:0] crc_upd;
    t_fault      ev_fault;
    logic        idx_ok;
    logic        count_bad;
    logic        is_last;
    logic [31:0] crc_final;

    esl_crc u_crc (
        .i_crc  (r_crc),
        .i_data ({i_item.event_flags, i_item.out_pattern, i_item.timestamp}),
        .o_crc  (crc_upd)
    );

    assign count_bad = (i_item.evt_total < 32'(MIN_EVENTS)) ||
                       (i_item.evt_total > 32'(MAX_EVENTS));
    assign idx_ok    = (i_item.evt_pos == 32'(r_next)) &&
                       (i_item.evt_pos < 32'(r_announced));
    assign is_last   = ({1'b0, i_item.evt_pos} + 33'd1) == 33'(r_announced);
    assign crc_final = r_crc ^ CRC_INIT;

    // Event checks in priority order.
    always_comb begin
        if ((i_item.out_pattern & ~r_mask) != '0) begin
            ev_fault = FLT_RESERVED;
        end else if (i_item.event_flags != '0) begin
            ev_fault = FLT_FLAGS;
        end else if (i_item.out_pattern == r_last_st) begin
            ev_fault = FLT_NO_CHANGE;
        end else if ((i_item.evt_pos != '0) && (i_item.timestamp <= r_last_time)) begin
            ev_fault = FLT_TIME_ORDER;
        end else if (is_last && (i_item.out_pattern != '0)) begin
            ev_fault = FLT_UNSAFE_LAST;
        end else begin
            ev_fault = FLT_NONE;
        end
    end

    always_comb begin
        t_result res;
        n_active    = r_active;
        n_committed = r_committed;
        n_announced = r_announced;
        n_next      = r_next;
        n_target    = r_target;
        n_crc       = r_crc;
        n_last_time = r_last_time;
        n_last_st   = r_last_st;
        res         = '{status: STAT_OK, fault: FLT_NONE, default: '0};

        case (i_item.cmd)
            CMD_BEGIN: begin
                if (count_bad) begin
                    n_active    = 1'b0;
                    n_committed = 1'b0;
                    res.status  = STAT_BAD_SEQUENCE;
                    res.fault   = FLT_COUNT;
                    res.report_b = 32'(FLT_COUNT);
                end else if (!i_item.sequencer_idle) begin
                    res.status = STAT_BAD_STATE;
                end else begin
                    n_committed  = 1'b0;
                    n_active     = 1'b1;
                    n_announced  = i_item.evt_total[CNT_W-1:0];
                    n_next       = '0;
                    n_target     = i_item.expected_crc;
                    n_crc        = CRC_INIT;
                    n_last_time  = '0;
                    n_last_st    = '0;
                    res.report_a = i_item.evt_total;
                    res.report_b = i_item.expected_crc;
                end
            end
            CMD_EVENT: begin
                if (!r_active) begin
                    res.status = STAT_BAD_STATE;
                end else if (!idx_ok) begin
                    n_active     = 1'b0;
                    n_committed  = 1'b0;
                    res.status   = STAT_BAD_INDEX;
                    res.report_a = i_item.evt_pos;
                    res.report_b = 32'(r_next);
                end else if (ev_fault != FLT_NONE) begin
                    n_active     = 1'b0;
                    n_committed  = 1'b0;
                    res.status   = STAT_BAD_SEQUENCE;
                    res.fault    = ev_fault;
                    res.report_a = i_item.evt_pos;
                    res.report_b = 32'(ev_fault);
                end else begin
                    n_crc           = crc_upd;
                    n_last_time     = i_item.timestamp;
                    n_last_st       = i_item.out_pattern;
                    n_next          = r_next + CNT_W'(1);
                    res.report_a    = i_item.evt_pos;
                    res.store_event = 1'b1;
                    res.store_index = i_item.evt_pos[SLOT_W-1:0];
                end
            end
            CMD_COMMIT: begin
                if (!r_active || (r_next != r_announced)) begin
                    n_active     = 1'b0;
                    n_committed  = 1'b0;
                    res.status   = STAT_BAD_STATE;
                    res.report_a = 32'(r_next);
                    res.report_b = 32'(r_announced);
                end else if (crc_final != r_target) begin
                    n_active     = 1'b0;
                    n_committed  = 1'b0;
                    res.status   = STAT_CRC_MISMATCH;
                    res.report_a = r_target;
                    res.report_b = crc_final;
                end else begin
                    n_active     = 1'b0;
                    n_committed  = 1'b1;
                    res.report_a = 32'(r_announced);
                    res.report_b = crc_final;
                end
            end
            CMD_CLEAR: begin
                n_active = 1'b0;
            end
            default: begin
                n_active = r_active;
            end
        endcase

        res.load_active    = n_active;
        res.load_committed = n_committed;
        o_result           = res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= MASK_RST;
        end else if (i_cfg_we) begin
            r_mask <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_committed <= 1'b0;
            r_announced <= '0;
            r_next      <= '0;
            r_target    <= '0;
            r_crc       <= CRC_INIT;
            r_last_time <= '0;
            r_last_st   <= '0;
        end else if (i_step) begin
            r_active    <= n_active;
            r_committed <= n_committed;
            r_announced <= n_announced;
            r_next      <= n_next;
            r_target    <= n_target;
            r_crc       <= n_crc;
            r_last_time <= n_last_time;
            r_last_st   <= n_last_st;
        end
    end

endmodule

// File: bench/event_sequence_load_checker_test.sv
// ----------------------------------------------------------------------------
// event_sequence_load_checker_test
// Self-checking bench for the event sequence load checker. Command beats are
// fed from a queue through a bursty valid/ready driver. Each accepted beat
// runs through a cycle-free model of the load state, which queues the
// response it predicts. A monitor stalls the result channel on its own
// pattern and compares every result beat, field by field, with the oldest
// predicted response. The output mask is changed between phases, while the
// block is idle.
// ----------------------------------------------------------------------------
module event_sequence_load_checker_test;
    timeunit 1ns;
    timeprecision 1ps;

    import esl_pkg::*;

    localparam int CLK_HALF       = 2;
    localparam int RESET_CYCLES   = 12;
    // A result is registered behind the input register that accepts its command
    // beat, so a short settle window is enough to see any stray result beat.
    localparam int SETTLE_CYCLES  = 8;
    // The longest correct quiet stretch is a receiver stall plus a sender gap
    // plus the phase turnaround.
    localparam int WATCHDOG_LIMIT = 1000;

    // Ways a generated sequence can be broken on purpose.
    typedef enum int {
        DEF_NONE,
        DEF_BAD_CRC,
        DEF_SKIP_INDEX,
        DEF_FLAGS,
        DEF_RESERVED,
        DEF_SAME_STATE,
        DEF_STALE_TIME,
        DEF_LIVE_FINAL,
        DEF_EARLY_COMMIT,
        DEF_CLEAR,
        DEF_BUSY,
        DEF_EXTRA_EVENT
    } t_defect;

    logic              i_clk            = 1'b0;
    logic              i_rst_n          = 1'b0;
    logic              i_cfg_we         = 1'b0;
    logic [31:0]       i_cfg_wdata      = '0;
    logic              i_valid          = 1'b0;
    logic              o_ready;
    logic [1:0]        i_cmd            = '0;
    logic [31:0]       i_evt_total      = '0;
    logic [31:0]       i_expected_crc   = '0;
    logic [31:0]       i_evt_pos        = '0;
    logic [63:0]       i_timestamp      = '0;
    logic [31:0]       i_out_pattern    = '0;
    logic [31:0]       i_event_flags    = '0;
    logic              i_sequencer_idle = 1'b0;
    logic              o_valid;
    logic              i_ready          = 1'b0;
    logic [2:0]        o_status;
    logic [2:0]        o_fault;
    logic [31:0]       o_report_a;
    logic [31:0]       o_report_b;
    logic              o_load_active;
    logic              o_load_committed;
    logic              o_store_event;
    logic [SLOT_W-1:0] o_store_index;

    // Command beats waiting to be sent, and responses waiting to arrive.
    t_item   command_queue[$];
    t_result awaited_responses[$];
    t_item   driven_item;
    int      items_queued = 0;
    int      mismatches   = 0;

    // Predicted load state, at its reset values.
    logic [31:0] out_mask      = MASK_RST;
    logic        ld_active     = 1'b0;
    logic        ld_committed  = 1'b0;
    logic [31:0] ld_count      = '0;
    logic [31:0] ld_next       = '0;
    logic [31:0] ld_target_crc = '0;
    logic [31:0] ld_crc        = CRC_INIT;
    logic [63:0] ld_last_time  = '0;
    logic [31:0] ld_last_state = '0;

    // Sender burst and receiver stall bookkeeping.
    int unsigned burst_left = 0;
    int unsigned gap_left   = 0;
    int unsigned run_left   = 0;
    int unsigned stall_left = 0;
    int unsigned quiet_cycles = 0;

    event_sequence_load_checker dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_cmd            (i_cmd),
        .i_evt_total      (i_evt_total),
        .i_expected_crc   (i_expected_crc),
        .i_evt_pos        (i_evt_pos),
        .i_timestamp      (i_timestamp),
        .i_out_pattern    (i_out_pattern),
        .i_event_flags    (i_event_flags),
        .i_sequencer_idle (i_sequencer_idle),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_status         (o_status),
        .o_fault          (o_fault),
        .o_report_a       (o_report_a),
        .o_report_b       (o_report_b),
        .o_load_active    (o_load_active),
        .o_load_committed (o_load_committed),
        .o_store_event    (o_store_event),
        .o_store_index    (o_store_index)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Reflected CRC-32 over one event: four words, timestamp low word first,
    // each word shifted in from its least significant bit.
    function automatic logic [31:0] event_crc(logic [31:0] crc, logic [63:0] ts,
                                              logic [31:0] st, logic [31:0] fl);
        logic [127:0] bits;
        logic [31:0]  c;
        bits = {fl, st, ts};
        c = crc;
        for (int b = 0; b < 128; b++) begin
            c = (c[0] ^ bits[b]) ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // Applies one accepted command beat to the predicted load state and
    // returns the response the block must give for it.
    function automatic t_result load_response(t_item it);
        t_result     r;
        t_fault      f;
        logic [31:0] sum;
        r = '0;
        case (it.cmd)
            CMD_BEGIN: begin
                // The count is checked before the sequencer being busy.
                if (it.evt_total < MIN_EVENTS || it.evt_total > MAX_EVENTS) begin
                    ld_active    = 1'b0;
                    ld_committed = 1'b0;
                    r.status     = STAT_BAD_SEQUENCE;
                    r.fault      = FLT_COUNT;
                    r.report_b   = 32'(FLT_COUNT);
                end else if (!it.sequencer_idle) begin
                    r.status = STAT_BAD_STATE;
                end else begin
                    ld_committed  = 1'b0;
                    ld_active     = 1'b1;
                    ld_count      = it.evt_total;
                    ld_next       = '0;
                    ld_target_crc = it.expected_crc;
                    ld_crc        = CRC_INIT;
                    ld_last_time  = '0;
                    ld_last_state = '0;
                    r.report_a    = it.evt_total;
                    r.report_b    = it.expected_crc;
                end
            end
            CMD_EVENT: begin
                if (!ld_active) begin
                    r.status = STAT_BAD_STATE;
                end else if (it.evt_pos != ld_next || it.evt_pos >= ld_count) begin
                    ld_active    = 1'b0;
                    ld_committed = 1'b0;
                    r.status     = STAT_BAD_INDEX;
                    r.report_a   = it.evt_pos;
                    r.report_b   = ld_next;
                end else begin
                    // The first fault that applies wins, in this order.
                    if ((it.out_pattern & ~out_mask) != '0) begin
                        f = FLT_RESERVED;
                    end else if (it.event_flags != '0) begin
                        f = FLT_FLAGS;
                    end else if (it.out_pattern == ld_last_state) begin
                        f = FLT_NO_CHANGE;
                    end else if (it.evt_pos != '0 && it.timestamp <= ld_last_time) begin
                        f = FLT_TIME_ORDER;
                    end else if ({1'b0, it.evt_pos} + 33'd1 == {1'b0, ld_count}
                                 && it.out_pattern != '0) begin
                        f = FLT_UNSAFE_LAST;
                    end else begin
                        f = FLT_NONE;
                    end
                    r.report_a = it.evt_pos;
                    if (f != FLT_NONE) begin
                        ld_active    = 1'b0;
                        ld_committed = 1'b0;
                        r.status     = STAT_BAD_SEQUENCE;
                        r.fault      = f;
                        r.report_b   = 32'(f);
                    end else begin
                        ld_crc = event_crc(ld_crc, it.timestamp, it.out_pattern,
                                           it.event_flags);
                        ld_last_time  = it.timestamp;
                        ld_last_state = it.out_pattern;
                        ld_next       = ld_next + 32'd1;
                        r.store_event = 1'b1;
                        r.store_index = it.evt_pos[SLOT_W-1:0];
                    end
                end
            end
            CMD_COMMIT: begin
                if (!ld_active || ld_next != ld_count) begin
                    r.report_a   = ld_next;
                    r.report_b   = ld_count;
                    ld_active    = 1'b0;
                    ld_committed = 1'b0;
                    r.status     = STAT_BAD_STATE;
                end else begin
                    sum       = ~ld_crc;
                    ld_active = 1'b0;
                    r.report_b = sum;
                    if (sum != ld_target_crc) begin
                        ld_committed = 1'b0;
                        r.status     = STAT_CRC_MISMATCH;
                        r.report_a   = ld_target_crc;
                    end else begin
                        ld_committed = 1'b1;
                        r.report_a   = ld_count;
                    end
                end
            end
            default: begin
                // Clear only drops the active load; a commit stays visible.
                ld_active = 1'b0;
            end
        endcase
        r.load_active    = ld_active;
        r.load_committed = ld_committed;
        return r;
    endfunction

    // A beat with every field random, so that fields the command ignores
    // still toggle all their bits.
    function automatic t_item scrambled_item(t_cmd c);
        t_item it;
        it.cmd            = c;
        it.evt_total      = $urandom;
        it.expected_crc   = $urandom;
        it.evt_pos        = $urandom;
        it.timestamp      = {$urandom, $urandom};
        it.out_pattern    = $urandom;
        it.event_flags    = $urandom;
        it.sequencer_idle = 1'($urandom_range(1, 0));
        return it;
    endfunction

    function automatic void queue_item(t_item it);
        command_queue.push_back(it);
        items_queued++;
    endfunction

    function automatic void queue_cmd(t_cmd c);
        queue_item(scrambled_item(c));
    endfunction

    function automatic void queue_begin(logic [31:0] count, logic [31:0] crc, logic idle);
        t_item it;
        it                = scrambled_item(CMD_BEGIN);
        it.evt_total      = count;
        it.expected_crc   = crc;
        it.sequencer_idle = idle;
        queue_item(it);
    endfunction

    function automatic void queue_event(logic [31:0] idx, logic [63:0] ts,
                                        logic [31:0] st, logic [31:0] fl);
        t_item it;
        it              = scrambled_item(CMD_EVENT);
        it.evt_pos      = idx;
        it.timestamp    = ts;
        it.out_pattern  = st;
        it.event_flags  = fl;
        queue_item(it);
    endfunction

    // A full load (begin, every event, commit) meant to pass under the current
    // mask, unless the defect breaks it, most defects at one random position.
    function automatic void queue_sequence(int unsigned count, t_defect defect);
        logic [31:0] states[$];
        logic [63:0] stamps[$];
        logic [31:0] crc;
        logic [31:0] st;
        logic [31:0] prev;
        logic [31:0] idx;
        logic [31:0] fl;
        logic [31:0] want;
        logic [63:0] ts;
        int unsigned pos;
        crc  = CRC_INIT;
        prev = '0;
        pos  = $urandom_range(count - 1, 0);
        ts   = ($urandom_range(3, 0) == 0) ? {$urandom, $urandom} : 64'($urandom);
        for (int unsigned i = 0; i < count; i++) begin
            st = '0;
            if (i + 1 < count) begin
                // Every state must differ from the last one, the first and
                // the one before the final zero must not be zero.
                st = $urandom & out_mask;
                for (int t = 0; t < 16; t++) begin
                    if (st == prev || ((i == 0 || i + 2 == count) && st == '0)) begin
                        st = $urandom & out_mask;
                    end
                end
            end
            if (i > 0) begin
                ts = ts + (($urandom_range(7, 0) == 0) ? 64'({$urandom, 4'h0})
                                                       : 64'($urandom_range(50, 1)));
            end
            states.push_back(st);
            stamps.push_back(ts);
            crc  = event_crc(crc, ts, st, '0);
            prev = st;
        end
        want = ~crc;
        if (defect == DEF_BAD_CRC) begin
            want = want ^ (32'd1 << $urandom_range(31, 0));
        end
        queue_begin(count, want, defect != DEF_BUSY);
        for (int unsigned i = 0; i < count; i++) begin
            idx = i;
            st  = states[i];
            ts  = stamps[i];
            fl  = '0;
            if (i == pos) begin
                case (defect)
                    DEF_SKIP_INDEX: idx = $urandom_range(1, 0) ? i + 1 : $urandom;
                    DEF_FLAGS:      fl = 32'd1 << $urandom_range(31, 0);
                    DEF_RESERVED:   st = st | (~out_mask & (32'd1 << $urandom_range(31, 0)));
                    DEF_SAME_STATE: st = (i == 0) ? '0 : states[i - 1];
                    DEF_STALE_TIME: ts = (i == 0) ? ts : stamps[i - 1] - $urandom_range(1, 0);
                    DEF_EARLY_COMMIT: queue_cmd(CMD_COMMIT);
                    DEF_CLEAR:      queue_cmd(CMD_CLEAR);
                    default: ;
                endcase
            end
            if (defect == DEF_LIVE_FINAL && i + 1 == count) begin
                st = (i == 0) ? out_mask : out_mask & ~states[i - 1];
            end
            queue_event(idx, ts, st, fl);
        end
        if (defect == DEF_EXTRA_EVENT) begin
            queue_event(count, stamps[count - 1] + 1, 32'd1, '0);
        end
        queue_cmd(CMD_COMMIT);
    endfunction

    // Mostly well-formed loads with random content, some broken on purpose,
    // and a share of random command beats in between.
    function automatic void queue_random(int n);
        int          goal;
        int unsigned count;
        t_item       it;
        goal = items_queued + n;
        while (items_queued < goal) begin
            if ($urandom_range(9, 0) < 8) begin
                case ($urandom_range(19, 0))
                    0:          count = $urandom_range(64, 31);
                    1, 2, 3, 4: count = $urandom_range(30, 7);
                    default:    count = $urandom_range(6, 1);
                endcase
                queue_sequence(count, $urandom_range(1, 0) ? DEF_NONE :
                               t_defect'($urandom_range(DEF_EXTRA_EVENT, DEF_BAD_CRC)));
            end else begin
                it = scrambled_item(t_cmd'($urandom_range(3, 0)));
                if (it.cmd == CMD_BEGIN && $urandom_range(1, 0)) begin
                    it.evt_total = $urandom_range(MAX_EVENTS, MIN_EVENTS);
                end
                if (it.cmd == CMD_EVENT && $urandom_range(1, 0)) begin
                    it.evt_pos = $urandom_range(7, 0);
                end
                queue_item(it);
            end
        end
    endfunction

    function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    // Waits until every queued beat has been sent and answered. Sampling on
    // the falling edge keeps this clear of the driver's own updates.
    task automatic wait_drained();
        do begin
            @(negedge i_clk);
        end while (command_queue.size() != 0 || i_valid || awaited_responses.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // The mask only changes while nothing is in flight, so the predicted
    // copy can follow it at once.
    task automatic write_output_mask(logic [31:0] m);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= m;
        out_mask     = m;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Driver: presents beats from the queue in bursts with gaps between
    // them. A beat that is not yet accepted is held unchanged; the response
    // is predicted on the edge that accepts it.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                awaited_responses.push_back(load_response(driven_item));
            end
            if (!i_valid || o_ready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (command_queue.size() != 0) begin
                    driven_item       = command_queue.pop_front();
                    i_cmd            <= driven_item.cmd;
                    i_evt_total      <= driven_item.evt_total;
                    i_expected_crc   <= driven_item.expected_crc;
                    i_evt_pos        <= driven_item.evt_pos;
                    i_timestamp      <= driven_item.timestamp;
                    i_out_pattern    <= driven_item.out_pattern;
                    i_event_flags    <= driven_item.event_flags;
                    i_sequencer_idle <= driven_item.sequencer_idle;
                    i_valid          <= 1'b1;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        // A third of the bursts run straight into the next.
                        burst_left = $urandom_range(24, 1);
                        gap_left   = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(12, 1);
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result beat against the oldest predicted
    // response, and stalls the result channel in runs of its own: mostly
    // short hiccups, now and then a long stall that backs up the pipeline.
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (awaited_responses.size() == 0) begin
                    $error("result beat arrived with no command waiting for it");
                    mismatches++;
                end else begin
                    want = awaited_responses.pop_front();
                    compare_field("status",         32'(want.status),   32'(o_status));
                    compare_field("fault",          32'(want.fault),    32'(o_fault));
                    compare_field("report_a",       want.report_a,      o_report_a);
                    compare_field("report_b",       want.report_b,      o_report_b);
                    compare_field("load_active",    32'(want.load_active),
                                  32'(o_load_active));
                    compare_field("load_committed", 32'(want.load_committed),
                                  32'(o_load_committed));
                    compare_field("store_event",    32'(want.store_event),
                                  32'(o_store_event));
                    compare_field("store_index",    32'(want.store_index),
                                  32'(o_store_index));
                end
            end
            if (stall_left != 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
                if (run_left != 0) begin
                    run_left--;
                end else begin
                    run_left   = $urandom_range(40, 1);
                    stall_left = ($urandom_range(3, 0) == 0) ? $urandom_range(30, 8)
                                                             : $urandom_range(3, 0);
                end
            end
        end
    end

    // Watchdog: a run that stops moving beats on either channel is stuck.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        logic [31:0] pair_crc;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, under the mask's reset value. Commands that find
        // no load, then the count limits and a busy sequencer on begin.
        queue_event('0, {$urandom, $urandom}, 32'h1, '0);
        queue_cmd(CMD_COMMIT);
        queue_cmd(CMD_CLEAR);
        queue_begin(32'd0, $urandom, 1'b1);
        queue_begin(MAX_EVENTS + 1, $urandom, 1'b1);
        queue_begin(MAX_EVENTS, $urandom, 1'b0);
        // Largest load, then an event far out of order ends it.
        queue_begin(MAX_EVENTS, 32'hFFFF_FFFF, 1'b1);
        queue_event(MAX_EVENTS - 1, '0, 32'h1, '0);
        // A one-event load can never pass: its only event is also the last,
        // so a nonzero state is unsafe at the end.
        queue_begin(MIN_EVENTS, $urandom, 1'b1);
        queue_event('0, 64'd1, 32'h80, '0);
        // A bit outside the reset mask, nonzero flags, and a first state of
        // zero that does not change anything.
        queue_begin(32'd3, $urandom, 1'b1);
        queue_event('0, 64'd1, 32'h100, '0);
        queue_begin(32'd3, $urandom, 1'b1);
        queue_event('0, 64'd1, 32'h1, 32'h8000_0000);
        queue_begin(32'd3, $urandom, 1'b1);
        queue_event('0, 64'd1, '0, '0);
        // A timestamp equal to the previous one is out of order.
        queue_begin(32'd3, $urandom, 1'b1);
        queue_event('0, 64'h10, 32'h5, '0);
        queue_event(32'd1, 64'h10, 32'h6, '0);
        // A clean two-event load at the top of the time range commits; a
        // second commit then finds no active load.
        pair_crc = event_crc(event_crc(CRC_INIT, 64'hFFFF_FFFF_FFFF_FFFE, 32'hFF, '0),
                             64'hFFFF_FFFF_FFFF_FFFF, '0, '0);
        queue_begin(32'd2, ~pair_crc, 1'b1);
        queue_event('0, 64'hFFFF_FFFF_FFFF_FFFE, 32'hFF, '0);
        queue_event(32'd1, 64'hFFFF_FFFF_FFFF_FFFF, '0, '0);
        queue_cmd(CMD_COMMIT);
        queue_cmd(CMD_COMMIT);
        // A complete load whose CRC does not match.
        queue_sequence(2, DEF_BAD_CRC);

        // Random part, one phase per mask setting.
        queue_random(130);
        wait_drained();
        write_output_mask(32'hFFFF_FFFF);
        queue_random(100);
        wait_drained();
        // With no bits allowed, every load that reaches its first event faults there.
        write_output_mask(32'h0000_0000);
        queue_random(30);
        wait_drained();
        write_output_mask($urandom);
        queue_random(90);
        wait_drained();
        write_output_mask(32'hFFFF_0000);
        queue_random(80);
        wait_drained();

        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
